// ----- hw/rtl/csp_pkg.sv -----
// shared types and constants for the cpu share percentage block
`default_nettype none

package csp_pkg;

  // field widths
  localparam int unsigned ENTRY_W = 3;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned SHARE_W = 8;

  // counter slots per entry and the scale of a share
  localparam int unsigned SLOTS   = 5;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned PERCENT = 100;

  // magnitude of a difference times the scale fits in this many bits
  localparam int unsigned NUM_W     = 38;
  localparam int unsigned DIV_STEPS = NUM_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // item kinds
  localparam logic KIND_CLEAR  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // input transaction
  typedef struct packed {
    logic              kind;
    logic [ENTRY_W-1:0] entry_index;
    logic [TICK_W-1:0]  user_ticks;
    logic [TICK_W-1:0]  nice_ticks;
    logic [TICK_W-1:0]  system_ticks;
    logic [TICK_W-1:0]  fourth_ticks;
    logic [TICK_W-1:0]  fifth_ticks;
  } csp_in_t;

  // output transaction
  typedef struct packed {
    logic [ENTRY_W-1:0] result_index;
    logic [SHARE_W-1:0] share_user;
    logic [SHARE_W-1:0] share_nice;
    logic [SHARE_W-1:0] share_system;
    logic [SHARE_W-1:0] share_slot3;
    logic [SHARE_W-1:0] share_slot4;
  } csp_out_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TICK_W-1:0] den;
    logic              neg;
  } csp_div_req_t;

  typedef struct packed {
    logic               done;
    logic [SHARE_W-1:0] share;
  } csp_div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/csp_ram.sv -----
// generic single-port ram with registered read
`default_nettype none

module csp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csp_div.sv -----
// sequential signed divider, two quotient bits per cycle, low byte result
`default_nettype none

module csp_div
  import csp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire csp_div_req_t req_i,
  output csp_div_rsp_t      rsp_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [TICK_W-1:0]    den_q;
  logic [TICK_W-1:0]    rem_q;
  logic [SHARE_W-1:0]   quo_q;
  logic                 neg_q;
  logic                 done_q;
  logic [SHARE_W-1:0]   share_q;

  logic [NUM_W-1:0]   num_d;
  logic [TICK_W-1:0]  rem_d;
  logic [SHARE_W-1:0] quo_d;

  // two restoring steps on the magnitudes
  always_comb begin
    logic [TICK_W:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_d[SHARE_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[SHARE_W-2:0], 1'b0};
      end
      rem_d = trial[TICK_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      neg_q <= req_i.neg;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      // truncation toward zero: negate the magnitude's low byte
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        share_q <= neg_q ? (~quo_d + 1'b1) : quo_d;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.share = share_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cpu_share_percentages.sv -----
// per-entry cpu share calculator: counter table, differences and shares
//
//   channel | signals                            | transaction
//   --------+------------------------------------+------------------------------
//   in      | in_valid_i, in_ready_o, in_data_i  | clear or sample for one entry
//   out     | out_valid_o, out_ready_i, out_data_o | five shares for one entry
//
// a clear touches only the per-entry flags; a sample makes two counter
// ram accesses per slot, then, unless it is the entry's first since reset
// or a clear, five shared divider runs of 19 steps of two quotient bits each
// reset clears the entry flags at once; stored counters of an entry read as
// zero until its first sample, so no clearing pass is needed
// a waiting result lets the next item in; a later result holds the block
`default_nettype none

module cpu_share_percentages
  import csp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire csp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output csp_out_t      out_data_o
);

  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned WIDE_W = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
  localparam int unsigned DEPTH  = SLOTS * MAX_ENTRIES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [SLOT_W-1:0]      slot_q;
  logic [MAX_ENTRIES-1:0] stored_valid_q;
  logic [MAX_ENTRIES-1:0] pending_q;
  logic                   out_valid_q;

  logic [IDX_W-1:0]   idx_q;
  logic [TICK_W-1:0]  fresh_q [SLOTS];
  logic [TICK_W-1:0]  diff_q  [SLOTS];
  logic [SHARE_W-1:0] share_q [SLOTS];
  logic [TICK_W-1:0]  sum_q;
  csp_out_t           out_q;

  logic [WIDE_W-1:0] in_idx_wide;
  logic [IDX_W-1:0]  in_idx;
  logic              in_range;
  logic              in_fire;
  logic              out_free;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [TICK_W-1:0] mem_rdata;
  logic [TICK_W-1:0] old_val;
  logic [TICK_W-1:0] diff_new;

  logic [TICK_W-1:0] cur_diff;
  logic [TICK_W-1:0] diff_mag;
  logic [TICK_W-1:0] den_mag;
  csp_div_req_t      div_req;
  csp_div_rsp_t      div_rsp;

  // input index decode
  assign in_idx_wide = WIDE_W'(in_data_i.entry_index);
  assign in_idx      = in_idx_wide[IDX_W-1:0];
  assign in_range    = 32'(in_data_i.entry_index) < MAX_ENTRIES;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // counter table access
  assign mem_we   = (state_q == ST_UPDATE);
  assign mem_addr = ADDR_W'(32'(idx_q) * SLOTS + 32'(slot_q));
  assign old_val  = stored_valid_q[idx_q] ? mem_rdata : '0;
  assign diff_new = fresh_q[slot_q] - old_val;

  csp_ram #(
    .WIDTH (TICK_W),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (fresh_q[slot_q]),
    .rdata_o (mem_rdata)
  );

  // divider operands: magnitudes and quotient sign
  assign cur_diff    = diff_q[slot_q];
  assign diff_mag    = cur_diff[TICK_W-1] ? (~cur_diff + 1'b1) : cur_diff;
  assign den_mag     = (sum_q == '0) ? TICK_W'(1) :
                       (sum_q[TICK_W-1] ? (~sum_q + 1'b1) : sum_q);
  assign div_req.start = (state_q == ST_DIV);
  assign div_req.num   = NUM_W'(diff_mag) * NUM_W'(PERCENT);
  assign div_req.den   = den_mag;
  assign div_req.neg   = cur_diff[TICK_W-1] ^ sum_q[TICK_W-1];

  csp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_range && (in_data_i.kind == KIND_SAMPLE)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (slot_q == SLOT_LAST) begin
          state_d = pending_q[idx_q] ? ST_IDLE : ST_DIV;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DIV: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = (slot_q == SLOT_LAST) ? ST_OUT : ST_DIV;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      slot_q         <= '0;
      stored_valid_q <= '0;
      pending_q      <= '1;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // output register: load a new result or drop the accepted one
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          slot_q <= '0;
          if (in_fire && in_range && (in_data_i.kind == KIND_CLEAR)) begin
            stored_valid_q[in_idx] <= 1'b0;
            pending_q[in_idx]      <= 1'b1;
          end
        end
        ST_UPDATE: begin
          if (slot_q == SLOT_LAST) begin
            slot_q                <= '0;
            stored_valid_q[idx_q] <= 1'b1;
            pending_q[idx_q]      <= 1'b0;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (div_rsp.done && (slot_q != SLOT_LAST)) begin
            slot_q <= slot_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          idx_q      <= in_idx;
          sum_q      <= '0;
          fresh_q[0] <= in_data_i.user_ticks;
          fresh_q[1] <= in_data_i.nice_ticks;
          fresh_q[2] <= in_data_i.system_ticks;
          // slots three and four take the swapped counters
          fresh_q[3] <= in_data_i.fifth_ticks;
          fresh_q[4] <= in_data_i.fourth_ticks;
        end
      end
      ST_UPDATE: begin
        diff_q[slot_q] <= diff_new;
        sum_q          <= sum_q + diff_new;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          share_q[slot_q] <= div_rsp.share;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_q.result_index <= ENTRY_W'(idx_q);
          out_q.share_user   <= share_q[0];
          out_q.share_nice   <= share_q[1];
          out_q.share_system <= share_q[2];
          out_q.share_slot3  <= share_q[3];
          out_q.share_slot4  <= share_q[4];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
